// ----- src/bic_pkg.sv -----
// Shared types and constants for the barometer integer compensation block.
// Used by bic_div and baro_integer_compensation_top; depends on nothing.
package bic_pkg;

    localparam int RAW_W      = 20;
    localparam int TEMP_W     = 32;
    localparam int PRESS_W    = 32;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_W      = 64;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_TEMP_CALIB = 2'd0,
        CFG_PRESS_LOW  = 2'd1,
        CFG_PRESS_HIGH = 2'd2,
        CFG_PRESS_LAST = 2'd3
    } cfg_index_t;

    localparam logic [20:0]        PRESS_FULL   = 21'd1048576;
    localparam logic signed [27:0] TFINE_OFFSET = 28'sd128000;
    localparam logic signed [31:0] TEMP_ROUND   = 32'sd128;
    localparam logic [11:0]        PRESS_SCALE  = 12'd3125;

    // Data that rides along the divider pipeline
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
    } div_side_t;

endpackage

// ----- src/bic_div.sv -----
// Pipelined 64-bit signed divider, one quotient bit per stage, truncating.
// Depends on bic_pkg for widths and the side data type.
module bic_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [bic_pkg::DIV_W-1:0]  in_num,
    input  logic signed [bic_pkg::DIV_W-1:0]  in_den,
    input  bic_pkg::div_side_t                in_side,
    output logic                              out_valid,
    output logic                              out_zero,
    output logic signed [bic_pkg::DIV_W-1:0]  out_quo,
    output bic_pkg::div_side_t                out_side
);

    localparam int W = bic_pkg::DIV_W;

    logic [W:0]         vld_reg;
    logic [W-1:0]       rem_reg  [0:W];
    logic [W-1:0]       quo_reg  [0:W];
    logic [W-1:0]       den_reg  [0:W];
    logic               neg_reg  [0:W];
    logic               zero_reg [0:W];
    bic_pkg::div_side_t side_reg [0:W];

    logic                out_vld_reg;
    logic                out_zero_reg;
    logic signed [W-1:0] out_quo_reg;
    bic_pkg::div_side_t  out_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[W-1:0], in_valid};
            out_vld_reg <= vld_reg[W];
        end
    end

    // Stage 0: take magnitudes
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            quo_reg[0]  <= in_num[W-1] ? (-in_num) : in_num;
            den_reg[0]  <= in_den[W-1] ? (-in_den) : in_den;
            neg_reg[0]  <= in_num[W-1] ^ in_den[W-1];
            zero_reg[0] <= (in_den == '0);
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;

        assign trial = {rem_reg[k-1], quo_reg[k-1][W-1]};
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!diff[W]) begin
                    rem_reg[k] <= diff[W-1:0];
                    quo_reg[k] <= {quo_reg[k-1][W-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= trial[W-1:0];
                    quo_reg[k] <= {quo_reg[k-1][W-2:0], 1'b0};
                end
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Restore the sign
    always_ff @(posedge aclk) begin
        if (en) begin
            out_quo_reg  <= neg_reg[W] ? $signed(-quo_reg[W]) : $signed(quo_reg[W]);
            out_zero_reg <= zero_reg[W];
            out_side_reg <= side_reg[W];
        end
    end

    assign out_valid = out_vld_reg;
    assign out_zero  = out_zero_reg;
    assign out_quo   = out_quo_reg;
    assign out_side  = out_side_reg;

endmodule

// ----- src/baro_integer_compensation_top.sv -----
// Barometer integer compensation: temperature and pressure from raw readings.
// Depends on bic_pkg and bic_div.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | raw_temperature, raw_pressure
//  m_      | out       | m_valid / m_ready    | temperature_centi, pressure_q24_8,
//          |           |                      | pressure_valid
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item enters per cycle while the skid register is empty; results are offered in input order.
// The item passes 85 registers: 12 front stages, 66 in the divider (magnitude,
// 64 quotient bits, sign restore) and 7 back stages counting the output register.
// Synchronous active-low reset clears valid bits and calibration registers.
// A full pipeline stalls as one; the output register plus a skid register keep
// s_ready independent of m_ready, so nothing is lost or repeated.
module baro_integer_compensation_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bic_pkg::RAW_W-1:0]           s_raw_temperature,
    input  logic [bic_pkg::RAW_W-1:0]           s_raw_pressure,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bic_pkg::TEMP_W-1:0]   m_temperature_centi,
    output logic [bic_pkg::PRESS_W-1:0]         m_pressure_q24_8,
    output logic                                m_pressure_valid,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [bic_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Calibration registers
    logic [47:0]        temp_calib_reg;
    logic [63:0]        press_low_reg;
    logic [63:0]        press_high_reg;
    logic signed [15:0] press_last_reg;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_last_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (bic_pkg::cfg_index_t'(cfg_index))
                bic_pkg::CFG_TEMP_CALIB: temp_calib_reg <= cfg_data[47:0];
                bic_pkg::CFG_PRESS_LOW:  press_low_reg  <= cfg_data;
                bic_pkg::CFG_PRESS_HIGH: press_high_reg <= cfg_data;
                bic_pkg::CFG_PRESS_LAST: press_last_reg <= $signed(cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_calib_reg[15:0];
    assign t2 = $signed(temp_calib_reg[31:16]);
    assign t3 = $signed(temp_calib_reg[47:32]);
    assign p1 = press_low_reg[15:0];
    assign p2 = $signed(press_low_reg[31:16]);
    assign p3 = $signed(press_low_reg[47:32]);
    assign p4 = $signed(press_low_reg[63:48]);
    assign p5 = $signed(press_high_reg[15:0]);
    assign p6 = $signed(press_high_reg[31:16]);
    assign p7 = $signed(press_high_reg[47:32]);
    assign p8 = $signed(press_high_reg[63:48]);
    assign p9 = press_last_reg;

    // Global advance: hold everything while the skid register is occupied
    logic skid_vld_reg;
    logic en;

    assign en      = !skid_vld_reg;
    assign s_ready = en && aresetn;

    // ---------------- front stages ----------------
    logic [11:0] fv_reg;
    logic [5:0]  bv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (en) begin
            fv_reg <= {fv_reg[10:0], s_valid};
        end
    end

    logic [20:0]              pline_reg [1:9];
    logic signed [31:0]       tline_reg [5:12];

    logic signed [18:0] s1_a_reg;
    logic signed [17:0] s1_b_reg;
    logic signed [34:0] s2_at_reg;
    logic signed [35:0] s2_bb_reg;
    logic signed [23:0] s3_v1_reg;
    logic signed [39:0] s3_bbt_reg;
    logic signed [26:0] s4_tf_reg;
    logic signed [27:0] s5_pv1_reg;
    logic signed [55:0] s6_sq_reg;
    logic signed [43:0] s6_p5_reg, s6_p2_reg;
    logic signed [44:0] s7_lo6_reg, s7_hi6_reg, s7_lo3_reg, s7_hi3_reg;
    logic signed [43:0] s7_p5_reg, s7_p2_reg;
    logic [63:0]        s8_sq6_reg, s8_sq3_reg;
    logic signed [43:0] s8_p5_reg, s8_p2_reg;
    logic [63:0]        s9_v2_reg, s9_v1a_reg;
    logic [47:0]        s10_lo1_reg;
    logic [31:0]        s10_hi1_reg;
    logic [63:0]        s10_x_reg;
    logic [63:0]        s11_den_reg;
    logic [43:0]        s11_xl_reg;
    logic [31:0]        s11_xh_reg;
    logic [63:0]        s12_num_reg, s12_den_reg;

    logic signed [31:0] tf32, tf5;
    logic [47:0]        hi1_full;
    logic [43:0]        xh_full;
    logic [63:0]        prod1;

    assign tf32     = {{5{s4_tf_reg[26]}}, s4_tf_reg};
    assign tf5      = (tf32 <<< 2) + tf32 + bic_pkg::TEMP_ROUND;
    assign hi1_full = s9_v1a_reg[63:32] * p1;
    assign xh_full  = s10_x_reg[63:32] * bic_pkg::PRESS_SCALE;
    assign prod1    = {16'b0, s10_lo1_reg} + {s10_hi1_reg, 32'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            // S1: offsets from T1, pressure complement
            s1_a_reg     <= $signed({2'b00, s_raw_temperature[19:3]}) -
                            $signed({2'b00, t1, 1'b0});
            s1_b_reg     <= $signed({2'b00, s_raw_temperature[19:4]}) -
                            $signed({2'b00, t1});
            pline_reg[1] <= bic_pkg::PRESS_FULL - {1'b0, s_raw_pressure};
            for (int k = 2; k <= 9; k++) begin
                pline_reg[k] <= pline_reg[k-1];
            end
            // S2
            s2_at_reg <= s1_a_reg * t2;
            s2_bb_reg <= s1_b_reg * s1_b_reg;
            // S3
            s3_v1_reg  <= s2_at_reg[34:11];
            s3_bbt_reg <= $signed(s2_bb_reg[35:12]) * t3;
            // S4: fine temperature
            s4_tf_reg <= $signed({{3{s3_v1_reg[23]}}, s3_v1_reg}) +
                         $signed({s3_bbt_reg[39], s3_bbt_reg[39:14]});
            // S5
            tline_reg[5] <= tf5 >>> 8;
            for (int k = 6; k <= 12; k++) begin
                tline_reg[k] <= tline_reg[k-1];
            end
            s5_pv1_reg <= $signed({s4_tf_reg[26], s4_tf_reg}) - bic_pkg::TFINE_OFFSET;
            // S6
            s6_sq_reg <= s5_pv1_reg * s5_pv1_reg;
            s6_p5_reg <= s5_pv1_reg * p5;
            s6_p2_reg <= s5_pv1_reg * p2;
            // S7: square split in two non-negative halves
            s7_lo6_reg <= $signed({1'b0, s6_sq_reg[27:0]}) * p6;
            s7_hi6_reg <= $signed({1'b0, s6_sq_reg[55:28]}) * p6;
            s7_lo3_reg <= $signed({1'b0, s6_sq_reg[27:0]}) * p3;
            s7_hi3_reg <= $signed({1'b0, s6_sq_reg[55:28]}) * p3;
            s7_p5_reg  <= s6_p5_reg;
            s7_p2_reg  <= s6_p2_reg;
            // S8
            s8_sq6_reg <= {{19{s7_lo6_reg[44]}}, s7_lo6_reg} + {s7_hi6_reg[35:0], 28'b0};
            s8_sq3_reg <= {{19{s7_lo3_reg[44]}}, s7_lo3_reg} + {s7_hi3_reg[35:0], 28'b0};
            s8_p5_reg  <= s7_p5_reg;
            s8_p2_reg  <= s7_p2_reg;
            // S9
            s9_v2_reg  <= s8_sq6_reg + {{3{s8_p5_reg[43]}}, s8_p5_reg, 17'b0} +
                          {{13{p4[15]}}, p4, 35'b0};
            s9_v1a_reg <= {{8{s8_sq3_reg[63]}}, s8_sq3_reg[63:8]} +
                          {{8{s8_p2_reg[43]}}, s8_p2_reg, 12'b0} + (64'd1 << 47);
            // S10
            s10_lo1_reg <= s9_v1a_reg[31:0] * p1;
            s10_hi1_reg <= hi1_full[31:0];
            s10_x_reg   <= {12'b0, pline_reg[9], 31'b0} - s9_v2_reg;
            // S11: divisor, numerator partials
            s11_den_reg <= {{33{prod1[63]}}, prod1[63:33]};
            s11_xl_reg  <= s10_x_reg[31:0] * bic_pkg::PRESS_SCALE;
            s11_xh_reg  <= xh_full[31:0];
            // S12
            s12_num_reg <= {20'b0, s11_xl_reg} + {s11_xh_reg, 32'b0};
            s12_den_reg <= s11_den_reg;
        end
    end

    // ---------------- divider ----------------
    logic                dv, dzero;
    logic signed [63:0]  dq;
    bic_pkg::div_side_t  din_side, dout_side;

    assign din_side.temp_centi = tline_reg[12];

    bic_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fv_reg[11]),
        .in_num   ($signed(s12_num_reg)),
        .in_den   ($signed(s12_den_reg)),
        .in_side  (din_side),
        .out_valid(dv),
        .out_zero (dzero),
        .out_quo  (dq),
        .out_side (dout_side)
    );

    // ---------------- back stages ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else if (en) begin
            bv_reg <= {bv_reg[4:0], dv};
        end
    end

    logic [63:0]        qv, qlh_full, qsq, v1full;
    logic signed [47:0] ph8_full, h9_full;

    assign qv       = {{13{dq[63]}}, dq[63:13]};
    assign qlh_full = qv[31:0] * qv[63:32];
    assign ph8_full = $signed(dq[63:32]) * p8;

    logic [63:0]        b1_p_reg, b2_p_reg, b3_p_reg;
    logic [63:0]        b1_qll_reg;
    logic [31:0]        b1_qlh_reg;
    logic signed [48:0] b1_pl8_reg;
    logic [31:0]        b1_ph8_reg;
    logic [63:0]        b2_qsq_reg, b2_v2_reg;
    logic signed [48:0] b3_l9_reg;
    logic [31:0]        b3_h9_reg;
    logic [63:0]        b3_v2s_reg;
    logic [63:0]        b4_v1_reg, b4_sum_reg;
    logic [63:0]        b5_sh_reg;
    logic [31:0]        b6_press_reg;
    logic               b6_pv_reg;
    logic               zline_reg [1:5];
    logic signed [31:0] tback_reg [1:6];
    logic [63:0]        tot, fin;

    assign qsq     = b2_qsq_reg;
    assign h9_full = $signed(qsq[63:32]) * p9;
    assign v1full  = {{15{b3_l9_reg[48]}}, b3_l9_reg} + {b3_h9_reg, 32'b0};
    assign tot     = b4_sum_reg + b4_v1_reg;
    assign fin     = b5_sh_reg + {{44{p7[15]}}, p7, 4'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            // B1
            b1_qll_reg   <= qv[31:0] * qv[31:0];
            b1_qlh_reg   <= qlh_full[31:0];
            b1_pl8_reg   <= $signed({1'b0, dq[31:0]}) * p8;
            b1_ph8_reg   <= ph8_full[31:0];
            b1_p_reg     <= dq;
            zline_reg[1] <= dzero;
            tback_reg[1] <= dout_side.temp_centi;
            for (int k = 2; k <= 5; k++) begin
                zline_reg[k] <= zline_reg[k-1];
            end
            for (int k = 2; k <= 6; k++) begin
                tback_reg[k] <= tback_reg[k-1];
            end
            // B2
            b2_qsq_reg <= b1_qll_reg + {b1_qlh_reg[30:0], 33'b0};
            b2_v2_reg  <= {{15{b1_pl8_reg[48]}}, b1_pl8_reg} + {b1_ph8_reg, 32'b0};
            b2_p_reg   <= b1_p_reg;
            // B3
            b3_l9_reg  <= $signed({1'b0, qsq[31:0]}) * p9;
            b3_h9_reg  <= h9_full[31:0];
            b3_v2s_reg <= {{19{b2_v2_reg[63]}}, b2_v2_reg[63:19]};
            b3_p_reg   <= b2_p_reg;
            // B4
            b4_v1_reg  <= {{25{v1full[63]}}, v1full[63:25]};
            b4_sum_reg <= b3_p_reg + b3_v2s_reg;
            // B5
            b5_sh_reg <= {{8{tot[63]}}, tot[63:8]};
            // B6: saturate, force zero when the divisor was zero
            if (zline_reg[5] || fin[63]) begin
                b6_press_reg <= '0;
            end else if (|fin[62:32]) begin
                b6_press_reg <= '1;
            end else begin
                b6_press_reg <= fin[31:0];
            end
            b6_pv_reg <= !zline_reg[5];
        end
    end

    // ---------------- output register and skid ----------------
    logic               out_vld_reg;
    logic signed [31:0] out_temp_reg, skid_temp_reg;
    logic [31:0]        out_press_reg, skid_press_reg;
    logic               out_pv_reg, skid_pv_reg;
    logic               take;

    assign take = out_vld_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (take) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (bv_reg[5]) begin
            if (out_vld_reg && !m_ready) begin
                skid_vld_reg <= 1'b1;
            end else begin
                out_vld_reg <= 1'b1;
            end
        end else if (take) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (take) begin
                out_temp_reg  <= skid_temp_reg;
                out_press_reg <= skid_press_reg;
                out_pv_reg    <= skid_pv_reg;
            end
        end else if (bv_reg[5]) begin
            if (out_vld_reg && !m_ready) begin
                skid_temp_reg  <= tback_reg[6];
                skid_press_reg <= b6_press_reg;
                skid_pv_reg    <= b6_pv_reg;
            end else begin
                out_temp_reg  <= tback_reg[6];
                out_press_reg <= b6_press_reg;
                out_pv_reg    <= b6_pv_reg;
            end
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_temperature_centi = out_temp_reg;
    assign m_pressure_q24_8    = out_press_reg;
    assign m_pressure_valid    = out_pv_reg;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for baro_integer_compensation_top: random and corner readings
// under several calibration sets. Depends on bic_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 85;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] temp_centi;
        logic [31:0]        press;
        logic               press_ok;
    } comp_result_t;

    // Predicts compensated readings and keeps the queue of pending results.
    class comp_scoreboard;
        logic [47:0] temp_cal;
        logic [63:0] press_lo;
        logic [63:0] press_hi;
        logic [15:0] press_last;
        comp_result_t pending[$];
        int errors;

        function void set_reg(bic_pkg::cfg_index_t idx, logic [63:0] value);
            case (idx)
                bic_pkg::CFG_TEMP_CALIB: temp_cal = value[47:0];
                bic_pkg::CFG_PRESS_LOW:  press_lo = value;
                bic_pkg::CFG_PRESS_HIGH: press_hi = value;
                bic_pkg::CFG_PRESS_LAST: press_last = value[15:0];
                default: ;
            endcase
        endfunction

        function comp_result_t compensate(logic [19:0] adc_t, logic [19:0] adc_p);
            comp_result_t r;
            longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
            longint a, b, v1, v2, tf, tc, p, q, num;
            t1 = longint'({48'd0, temp_cal[15:0]});
            t2 = longint'($signed(temp_cal[31:16]));
            t3 = longint'($signed(temp_cal[47:32]));
            p1 = longint'({48'd0, press_lo[15:0]});
            p2 = longint'($signed(press_lo[31:16]));
            p3 = longint'($signed(press_lo[47:32]));
            p4 = longint'($signed(press_lo[63:48]));
            p5 = longint'($signed(press_hi[15:0]));
            p6 = longint'($signed(press_hi[31:16]));
            p7 = longint'($signed(press_hi[47:32]));
            p8 = longint'($signed(press_hi[63:48]));
            p9 = longint'($signed(press_last));
            a = longint'(adc_t >> 3) - (t1 << 1);
            v1 = (a * t2) >>> 11;
            b = longint'(adc_t >> 4) - t1;
            v2 = (((b * b) >>> 12) * t3) >>> 14;
            tf = v1 + v2;
            tc = (tf * 5 + 128) >>> 8;
            r.temp_centi = tc[31:0];
            v1 = tf - 128000;
            v2 = v1 * v1 * p6;
            v2 += (v1 * p5) << 17;
            v2 += p4 << 35;
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
            v1 = (((64'sd1 << 47) + v1) * p1) >>> 33;
            if (v1 == 0) begin
                r.press = '0;
                r.press_ok = 1'b0;
            end else begin
                p = 1048576 - longint'(adc_p);
                num = ((p << 31) - v2) * 3125;
                // wrap the one overflowing quotient instead of trapping
                if (num == 64'sh8000000000000000 && v1 == -1) p = num;
                else p = num / v1;
                q = p >>> 13;
                v1 = (p9 * q * q) >>> 25;
                v2 = (p8 * p) >>> 19;
                p = ((p + v1 + v2) >>> 8) + (p7 << 4);
                if (p < 0) r.press = '0;
                else if (p > 64'sh00000000FFFFFFFF) r.press = 32'hFFFFFFFF;
                else r.press = p[31:0];
                r.press_ok = 1'b1;
            end
            return r;
        endfunction

        function void note_reading(logic [19:0] adc_t, logic [19:0] adc_p);
            pending.push_back(compensate(adc_t, adc_p));
        endfunction

        function void check_result(logic signed [31:0] tc, logic [31:0] pr, logic ok);
            comp_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result temperature_centi=%0d", tc);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (tc !== e.temp_centi) begin
                $error("temperature_centi expected %0d actual %0d", e.temp_centi, tc);
                errors++;
            end
            if (pr !== e.press) begin
                $error("pressure_q24_8 expected %0h actual %0h", e.press, pr);
                errors++;
            end
            if (ok !== e.press_ok) begin
                $error("pressure_valid expected %0b actual %0b", e.press_ok, ok);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [bic_pkg::RAW_W-1:0] s_raw_temperature = '0;
    logic [bic_pkg::RAW_W-1:0] s_raw_pressure = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [bic_pkg::TEMP_W-1:0] m_temperature_centi;
    logic [bic_pkg::PRESS_W-1:0] m_pressure_q24_8;
    logic m_pressure_valid;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [bic_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    comp_scoreboard sb = new();
    bit calm = 1'b0;
    int idle_cycles = 0;

    always #5 aclk = ~aclk;

    baro_integer_compensation_top dut (.*);

    // Result side: check on accept, stall in random bursts.
    initial begin : result_side
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_temperature_centi, m_pressure_q24_8, m_pressure_valid);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 12) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Hold valid high across consecutive writes; the caller drops it.
    task automatic write_reg(bic_pkg::cfg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, value);
    endtask

    task automatic load_calibration(logic [47:0] tcal, logic [63:0] lo, logic [63:0] hi,
                                    logic [15:0] last);
        write_reg(bic_pkg::CFG_TEMP_CALIB, {16'd0, tcal});
        write_reg(bic_pkg::CFG_PRESS_LOW, lo);
        write_reg(bic_pkg::CFG_PRESS_HIGH, hi);
        write_reg(bic_pkg::CFG_PRESS_LAST, {48'd0, last});
        cfg_valid <= 1'b0;
    endtask

    // Drive one reading; hold valid and payload until taken.
    task automatic send_reading(logic [19:0] adc_t, logic [19:0] adc_p);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_temperature <= adc_t;
        s_raw_pressure <= adc_p;
        do @(posedge aclk); while (!s_ready);
        sb.note_reading(adc_t, adc_p);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // Readings mostly around typical values so the pressure path stays in range; one in four is fully random.
    task automatic random_readings(int count);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0)
                send_reading(20'($urandom), 20'($urandom));
            else
                send_reading(20'($urandom_range(400000, 600000)),
                             20'($urandom_range(250000, 450000)));
        end
    endtask

    localparam logic [47:0] TCAL_TYP = {16'd50, 16'd26435, 16'd27504};
    localparam logic [63:0] PLO_TYP  = {16'd2855, -16'sd2508, -16'sd10685, 16'd36477};
    localparam logic [63:0] PHI_TYP  = {-16'sd10230, 16'd15500, -16'sd7, 16'd140};
    localparam logic [15:0] P9_TYP   = 16'd4760;

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers at reset: divisor is zero, so pressure is invalid.
        send_reading(20'd519888, 20'd415148);
        send_reading(20'hFFFFF, 20'hFFFFF);
        drain();

        load_calibration(TCAL_TYP, PLO_TYP, PHI_TYP, P9_TYP);
        send_reading(20'd519888, 20'd415148);
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'd0);
        send_reading(20'd0, 20'hFFFFF);
        send_reading(20'h55555, 20'hAAAAA);
        send_reading(20'hAAAAA, 20'h55555);
        // Raw pressure at both ends with huge p7 pushes toward saturation at the top.
        drain();
        load_calibration(TCAL_TYP, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1},
                         {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
        send_reading(20'd519888, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        drain();
        load_calibration({16'h8000, 16'h8000, 16'hFFFF}, {48'h800080008000, 16'hFFFF},
                         {64'h8000800080008000}, 16'h8000);
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'd1);
        send_reading(20'd12345, 20'hFFFFF);
        drain();
        load_calibration('1, '1, '1, '1);
        send_reading(20'd0, 20'd0);
        send_reading(20'hFFFFF, 20'hFFFFF);
        drain();

        load_calibration(TCAL_TYP, PLO_TYP, PHI_TYP, P9_TYP);
        random_readings(300);
        drain();

        // Calibration words perturbed around typical values, the others fully random.
        load_calibration({16'($urandom_range(0, 100)), 16'($urandom_range(20000, 30000)),
                          16'($urandom_range(20000, 30000))},
                         {16'($urandom_range(2000, 4000)), 16'($urandom), 16'($urandom),
                          16'($urandom_range(30000, 40000))},
                         {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                         16'($urandom));
        random_readings(250);
        drain();

        load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                         {$urandom, $urandom}, 16'($urandom));
        random_readings(200);
        drain();

        load_calibration(TCAL_TYP, PLO_TYP, PHI_TYP, P9_TYP);
        calm = 1'b1;
        random_readings(250);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
